### hdl/set_assoc_cache_random_replace_unit_macros.svh
// Assertion macros shared by the tag store logic.
`ifndef SET_ASSOC_CACHE_RANDOM_REPLACE_UNIT_MACROS_SVH
`define SET_ASSOC_CACHE_RANDOM_REPLACE_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define SACR_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tag store check failed");
`define SACR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tag store check failed");
`else
`define SACR_ASSERT_SAME(lbl, ante, cons)
`define SACR_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

### hdl/sacr_pkg.sv
package sacr_pkg;

    localparam int TOTAL_BLOCKS = 2048;
    localparam int TAG_WIDTH    = 32;
    localparam int BLOCKS_LOG2  = $clog2(TOTAL_BLOCKS + 1) - 1;
    localparam int LINE_W       = BLOCKS_LOG2;
    localparam int LINE_COUNT   = 1 << BLOCKS_LOG2;

    localparam int ADDR_W    = 32;
    localparam int WAY_OUT_W = 11;
    localparam int COUNT_W   = 32;
    localparam int GEO_W     = 4;
    localparam int CFG_IDX_W = 2;
    localparam int LFSR_W    = 16;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS_LOG2   = 2'd2;

    localparam logic [GEO_W-1:0]  RESET_OFFSET_BITS = 4'd4;
    localparam logic [GEO_W-1:0]  RESET_SET_BITS    = 4'd8;
    localparam logic [GEO_W-1:0]  RESET_WAYS_LOG2   = 4'd3;
    localparam logic [LFSR_W-1:0] LFSR_SEED         = 16'hACE1;

    typedef struct packed {
        logic [LINE_W-1:0]    base;
        logic [LINE_W-1:0]    way_mask;
        logic [TAG_WIDTH-1:0] tag;
    } job_t;

    typedef struct packed {
        logic                 valid;
        logic [TAG_WIDTH-1:0] tag;
    } line_t;

    localparam int LINE_BITS = $bits(line_t);

    typedef struct packed {
        logic clearing;
    } back_status_t;

endpackage

### hdl/sacr_req_if.sv
interface sacr_req_if;
    import sacr_pkg::*;

    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] address;

    modport source (output valid, output address, input ready);
    modport sink (input valid, input address, output ready);
endinterface

### hdl/sacr_rsp_if.sv
interface sacr_rsp_if;
    import sacr_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 hit;
    logic [WAY_OUT_W-1:0] way;
    logic                 evicted;
    logic [COUNT_W-1:0]   hit_count;
    logic [COUNT_W-1:0]   miss_count;

    modport source (output valid, output hit, output way, output evicted,
                    output hit_count, output miss_count, input ready);
    modport sink (input valid, input hit, input way, input evicted,
                  input hit_count, input miss_count, output ready);
endinterface

### hdl/sacr_ram.sv
module sacr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hdl/sacr_front.sv
module sacr_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            write_en,
    input  logic [sacr_pkg::CFG_IDX_W-1:0]  write_index,
    input  logic [sacr_pkg::GEO_W-1:0]      write_data,
    sacr_req_if.sink                        req,
    input  sacr_pkg::back_status_t          status,
    output logic                            push_valid,
    input  logic                            push_ready,
    output sacr_pkg::job_t                  push_job
);
    import sacr_pkg::*;

    localparam logic [GEO_W-1:0] MAX_LOG2 = GEO_W'(BLOCKS_LOG2);

    logic [GEO_W-1:0]  offset_bits_reg, offset_bits_next;
    logic [GEO_W-1:0]  set_bits_reg, set_bits_next;
    logic [GEO_W-1:0]  ways_log2_reg, ways_log2_next;
    logic [GEO_W-1:0]  ways_eff;
    logic [GEO_W-1:0]  sets_room;
    logic [GEO_W-1:0]  sets_eff;
    logic [ADDR_W-1:0] block;
    logic [ADDR_W-1:0] tag_full;
    logic [LINE_W-1:0] set_index;

    always_comb
    begin
        offset_bits_next = offset_bits_reg;
        set_bits_next    = set_bits_reg;
        ways_log2_next   = ways_log2_reg;
        if (write_en)
        begin
            case (write_index)
                CFG_OFFSET_BITS: offset_bits_next = write_data;
                CFG_SET_BITS:    set_bits_next    = write_data;
                CFG_WAYS_LOG2:   ways_log2_next   = write_data;
                default:         offset_bits_next = offset_bits_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_bits_reg <= RESET_OFFSET_BITS;
            set_bits_reg    <= RESET_SET_BITS;
            ways_log2_reg   <= RESET_WAYS_LOG2;
        end
        else
        begin
            offset_bits_reg <= offset_bits_next;
            set_bits_reg    <= set_bits_next;
            ways_log2_reg   <= ways_log2_next;
        end
    end

    // Oversized geometry is clamped so that the set and way fields never
    // address beyond the store.
    assign ways_eff  = (ways_log2_reg > MAX_LOG2) ? MAX_LOG2 : ways_log2_reg;
    assign sets_room = MAX_LOG2 - ways_eff;
    assign sets_eff  = (set_bits_reg > sets_room) ? sets_room : set_bits_reg;

    assign block     = req.address >> offset_bits_reg;
    assign tag_full  = block >> sets_eff;
    assign set_index = LINE_W'(block) & ~({LINE_W{1'b1}} << sets_eff);

    assign push_job.base     = set_index << ways_eff;
    assign push_job.way_mask = ~({LINE_W{1'b1}} << ways_eff);
    assign push_job.tag      = TAG_WIDTH'(tag_full);

    assign push_valid = req.valid && !status.clearing;
    assign req.ready  = push_ready && !status.clearing;

endmodule

### hdl/sacr_queue.sv
module sacr_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  sacr_pkg::job_t push_job,
    output logic           pop_valid,
    input  logic           pop_ready,
    output sacr_pkg::job_t pop_job
);
    import sacr_pkg::*;

    localparam logic [QPTR_W-1:0] LAST_PTR = QPTR_W'(QUEUE_DEPTH - 1);
    localparam logic [QCNT_W-1:0] FULL_CNT = QCNT_W'(QUEUE_DEPTH);

    job_t              entries_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = entries_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + QPTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + QPTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

### hdl/sacr_back.sv
`include "set_assoc_cache_random_replace_unit_macros.svh"

module sacr_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           pop_valid,
    output logic                           pop_ready,
    input  sacr_pkg::job_t                 pop_job,
    output sacr_pkg::back_status_t         status,
    output logic                           ram_we,
    output logic [sacr_pkg::LINE_W-1:0]    ram_waddr,
    output sacr_pkg::line_t                ram_wdata,
    output logic                           ram_re,
    output logic [sacr_pkg::LINE_W-1:0]    ram_raddr,
    input  sacr_pkg::line_t                ram_rdata,
    sacr_rsp_if.source                     rsp
);
    import sacr_pkg::*;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_RESULT
    } state_t;

    localparam logic [LINE_W-1:0] LAST_LINE = LINE_W'(LINE_COUNT - 1);

    state_t               state_reg, state_next;
    logic [LINE_W-1:0]    clr_addr_reg, clr_addr_next;
    job_t                 job_reg, job_next;
    logic [LINE_W-1:0]    issue_way_reg, issue_way_next;
    logic                 issue_done_reg, issue_done_next;
    logic                 rd_pend_reg, rd_pend_next;
    logic [LINE_W-1:0]    rd_way_reg, rd_way_next;
    logic                 hit_found_reg, hit_found_next;
    logic                 free_found_reg, free_found_next;
    logic [LINE_W-1:0]    sel_way_reg, sel_way_next;
    logic [LFSR_W-1:0]    lfsr_reg, lfsr_next;
    logic [COUNT_W-1:0]   hits_reg, hits_next;
    logic [COUNT_W-1:0]   misses_reg, misses_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 out_hit_reg, out_hit_next;
    logic [WAY_OUT_W-1:0] out_way_reg, out_way_next;
    logic                 out_evicted_reg, out_evicted_next;
    logic [COUNT_W-1:0]   out_hits_reg, out_hits_next;
    logic [COUNT_W-1:0]   out_misses_reg, out_misses_next;

    logic                 fire;
    logic [LINE_W-1:0]    result_way;
    logic                 result_evicted;

    assign fire           = (state_reg == ST_RESULT) && (!out_valid_reg || rsp.ready);
    assign result_evicted = !hit_found_reg && !free_found_reg;
    assign result_way     = result_evicted ? (LINE_W'(lfsr_reg) & job_reg.way_mask)
                                           : sel_way_reg;

    assign pop_ready       = (state_reg == ST_IDLE);
    assign status.clearing = (state_reg == ST_CLEAR);

    assign ram_re    = (state_reg == ST_SCAN) && !issue_done_reg;
    assign ram_raddr = job_reg.base | issue_way_reg;

    always_comb
    begin
        ram_we          = 1'b0;
        ram_waddr       = clr_addr_reg;
        ram_wdata.valid = 1'b0;
        ram_wdata.tag   = job_reg.tag;
        if (state_reg == ST_CLEAR)
        begin
            ram_we = 1'b1;
        end
        else if (fire && !hit_found_reg)
        begin
            ram_we          = 1'b1;
            ram_waddr       = job_reg.base | result_way;
            ram_wdata.valid = 1'b1;
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        clr_addr_next    = clr_addr_reg;
        job_next         = job_reg;
        issue_way_next   = issue_way_reg;
        issue_done_next  = issue_done_reg;
        rd_pend_next     = ram_re;
        rd_way_next      = issue_way_reg;
        hit_found_next   = hit_found_reg;
        free_found_next  = free_found_reg;
        sel_way_next     = sel_way_reg;
        lfsr_next        = lfsr_reg;
        hits_next        = hits_reg;
        misses_next      = misses_reg;
        out_valid_next   = rsp.ready ? 1'b0 : out_valid_reg;
        out_hit_next     = out_hit_reg;
        out_way_next     = out_way_reg;
        out_evicted_next = out_evicted_reg;
        out_hits_next    = out_hits_reg;
        out_misses_next  = out_misses_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + LINE_W'(1);
                if (clr_addr_reg == LAST_LINE)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (pop_valid)
                begin
                    job_next        = pop_job;
                    issue_way_next  = '0;
                    issue_done_next = 1'b0;
                    hit_found_next  = 1'b0;
                    free_found_next = 1'b0;
                    state_next      = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (!issue_done_reg)
                begin
                    if (issue_way_reg == job_reg.way_mask)
                    begin
                        issue_done_next = 1'b1;
                    end
                    else
                    begin
                        issue_way_next = issue_way_reg + LINE_W'(1);
                    end
                end
                if (rd_pend_reg)
                begin
                    if (ram_rdata.valid && (ram_rdata.tag == job_reg.tag))
                    begin
                        hit_found_next = 1'b1;
                        sel_way_next   = rd_way_reg;
                        state_next     = ST_RESULT;
                    end
                    else
                    begin
                        if (!ram_rdata.valid && !free_found_reg)
                        begin
                            free_found_next = 1'b1;
                            sel_way_next    = rd_way_reg;
                        end
                        if (rd_way_reg == job_reg.way_mask)
                        begin
                            state_next = ST_RESULT;
                        end
                    end
                end
            end
            ST_RESULT:
            begin
                if (fire)
                begin
                    if (hit_found_reg)
                    begin
                        hits_next = (hits_reg == '1) ? hits_reg : hits_reg + COUNT_W'(1);
                    end
                    else
                    begin
                        misses_next = (misses_reg == '1) ? misses_reg
                                                         : misses_reg + COUNT_W'(1);
                    end
                    if (result_evicted)
                    begin
                        lfsr_next = {lfsr_reg[0] ^ lfsr_reg[2] ^ lfsr_reg[3] ^ lfsr_reg[5],
                                     lfsr_reg[LFSR_W-1:1]};
                    end
                    out_valid_next   = 1'b1;
                    out_hit_next     = hit_found_reg;
                    out_way_next     = WAY_OUT_W'(result_way);
                    out_evicted_next = result_evicted;
                    out_hits_next    = hits_next;
                    out_misses_next  = misses_next;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_addr_reg   <= '0;
            issue_done_reg <= 1'b0;
            rd_pend_reg    <= 1'b0;
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            lfsr_reg       <= LFSR_SEED;
            hits_reg       <= '0;
            misses_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            issue_done_reg <= issue_done_next;
            rd_pend_reg    <= rd_pend_next;
            hit_found_reg  <= hit_found_next;
            free_found_reg <= free_found_next;
            lfsr_reg       <= lfsr_next;
            hits_reg       <= hits_next;
            misses_reg     <= misses_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg         <= job_next;
        issue_way_reg   <= issue_way_next;
        rd_way_reg      <= rd_way_next;
        sel_way_reg     <= sel_way_next;
        out_hit_reg     <= out_hit_next;
        out_way_reg     <= out_way_next;
        out_evicted_reg <= out_evicted_next;
        out_hits_reg    <= out_hits_next;
        out_misses_reg  <= out_misses_next;
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.hit        = out_hit_reg;
    assign rsp.way        = out_way_reg;
    assign rsp.evicted    = out_evicted_reg;
    assign rsp.hit_count  = out_hits_reg;
    assign rsp.miss_count = out_misses_reg;

    `SACR_ASSERT_SAME(a_hit_not_evicted, out_valid_reg, !(out_hit_reg && out_evicted_reg))
    `SACR_ASSERT_SAME(a_way_in_set, state_reg == ST_RESULT,
                      (result_way & ~job_reg.way_mask) == '0)
    `SACR_ASSERT_SAME(a_no_read_on_write, ram_we, !ram_re)
    `SACR_ASSERT_NEXT(a_result_shown, fire, out_valid_reg)

endmodule

### hdl/set_assoc_cache_random_replace_unit.sv
// Tag store of a set-associative cache with random replacement. Each address beat
// yields one result beat. After reset the store runs a clearing pass over all 2048
// lines, one line per cycle, during which no address is accepted; configuration
// writes are taken at any time. The ways of a set are read from the tag RAM one
// per cycle through its single read port, so a miss reads every way of the set
// (eight ways at the reset geometry) and a hit ends after the matching way is
// read. A two-entry queue sits between the address decoder and the lookup
// sequencer, and the result register lets a finished beat wait while the next
// address is taken.
module set_assoc_cache_random_replace_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           write_en,
    input  logic [sacr_pkg::CFG_IDX_W-1:0] write_index,
    input  logic [sacr_pkg::GEO_W-1:0]     write_data,
    sacr_req_if.sink                       req,
    sacr_rsp_if.source                     rsp
);
    import sacr_pkg::*;

    back_status_t      status;
    logic              push_valid;
    logic              push_ready;
    job_t              push_job;
    logic              pop_valid;
    logic              pop_ready;
    job_t              pop_job;
    logic              ram_we;
    logic [LINE_W-1:0] ram_waddr;
    line_t             ram_wdata;
    logic              ram_re;
    logic [LINE_W-1:0] ram_raddr;
    line_t             ram_rdata;

    sacr_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .write_en    (write_en),
        .write_index (write_index),
        .write_data  (write_data),
        .req         (req),
        .status      (status),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_job    (push_job)
    );

    sacr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    sacr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_job   (pop_job),
        .status    (status),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .rsp       (rsp)
    );

    sacr_ram #(
        .WIDTH (LINE_BITS),
        .DEPTH (LINE_COUNT)
    ) u_tag_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule
